// File: hdl/hashed_timing_wheel_unit_macros.svh
// Assertion macros used by the timing wheel datapath.
`ifndef HASHED_TIMING_WHEEL_UNIT_MACROS_SVH
`define HASHED_TIMING_WHEEL_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HTW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("htw assertion failed");

// Next-cycle implication, checked out of reset.
`define HTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htw assertion failed");

`endif

// File: hdl/htw_pkg.sv
// Types and constants of the hashed timing wheel.
package htw_pkg;

    localparam int DIV_NW = 32;
    localparam int DIV_DW = 16;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STOP  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_STOP    = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;
    localparam logic [1:0] KIND_TICK    = 2'd3;

    localparam logic CFG_GRAN  = 1'b0;
    localparam logic CFG_SLOTS = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  timer_id;
        logic [31:0] delay;
        logic [31:0] reload_interval;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  handle;
        logic        was_running;
        logic [5:0]  active_count;
        logic [5:0]  hiwater_mark;
        logic [31:0] expired_total;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        DS_TICKS,
        DS_ROUNDS,
        DS_SLOT,
        DS_ADV
    } t_div_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV_TICKS,
        ST_WAIT_TICKS,
        ST_DIV_ROUNDS,
        ST_WAIT_ROUNDS,
        ST_DIV_SLOT,
        ST_WAIT_SLOT,
        ST_START_FIN,
        ST_STOP,
        ST_ADV,
        ST_WAIT_ADV,
        ST_SCAN,
        ST_REARM,
        ST_EXPIRE,
        ST_TICK_FIN
    } t_state;

    typedef struct packed {
        logic     load_in;
        logic     div_start;
        t_div_sel div_sel;
        logic     arm_write;
        logic     start_commit;
        logic     stop_commit;
        logic     scan_clr;
        logic     scan_visit;
        logic     expire_commit;
        logic     tick_done;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       id_ok;
        logic       div_done;
        logic       out_free;
        logic       scan_end;
        logic       expire;
        logic       periodic;
    } t_dp_sts;

endpackage

// File: hdl/htw_div.sv
// Restoring divider, one quotient bit per cycle.
module htw_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [htw_pkg::DIV_NW-1:0] i_num,
    input  logic [htw_pkg::DIV_DW-1:0] i_den,
    output logic                       o_done,
    output logic [htw_pkg::DIV_NW-1:0] o_quo,
    output logic [htw_pkg::DIV_DW-1:0] o_rem
);
    import htw_pkg::*;

    localparam int CNTW = $clog2(DIV_NW);

    logic              r_busy;
    logic              r_done;
    logic [CNTW-1:0]   r_cnt;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   rem_sh;
    logic              fits;

    assign rem_sh = {r_rem, r_quo[DIV_NW-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NW-2:0], fits};
            r_rem <= fits ? DIV_DW'(rem_sh - {1'b0, r_den}) : rem_sh[DIV_DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// File: hdl/htw_ctrl.sv
// Sequencer for start, stop, tick scan and re-arm.
module htw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  htw_pkg::t_dp_sts i_sts,
    output htw_pkg::t_dp_cmd o_cmd
);
    import htw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:        if (i_in_valid) n_state = ST_DECODE;
            ST_DECODE: begin
                if (i_sts.action == ACT_TICK) n_state = ST_ADV;
                else if (i_sts.action == ACT_START && i_sts.id_ok) n_state = ST_DIV_TICKS;
                else if (i_sts.action == ACT_STOP && i_sts.id_ok) n_state = ST_STOP;
                else n_state = ST_IDLE;
            end
            ST_DIV_TICKS:   n_state = ST_WAIT_TICKS;
            ST_WAIT_TICKS:  if (i_sts.div_done) n_state = ST_DIV_ROUNDS;
            ST_DIV_ROUNDS:  n_state = ST_WAIT_ROUNDS;
            ST_WAIT_ROUNDS: if (i_sts.div_done) n_state = ST_DIV_SLOT;
            ST_DIV_SLOT:    n_state = ST_WAIT_SLOT;
            ST_WAIT_SLOT: begin
                if (i_sts.div_done) begin
                    n_state = (i_sts.action == ACT_TICK) ? ST_REARM : ST_START_FIN;
                end
            end
            ST_START_FIN:   if (i_sts.out_free) n_state = ST_IDLE;
            ST_STOP:        if (i_sts.out_free) n_state = ST_IDLE;
            ST_ADV:         n_state = ST_WAIT_ADV;
            ST_WAIT_ADV:    if (i_sts.div_done) n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_sts.scan_end) n_state = ST_TICK_FIN;
                else if (i_sts.expire) n_state = i_sts.periodic ? ST_DIV_TICKS : ST_EXPIRE;
            end
            ST_REARM:       n_state = ST_EXPIRE;
            ST_EXPIRE:      if (i_sts.out_free) n_state = ST_SCAN;
            ST_TICK_FIN:    if (i_sts.out_free) n_state = ST_IDLE;
            default:        n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            ST_DIV_TICKS: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DS_TICKS;
            end
            ST_DIV_ROUNDS: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DS_ROUNDS;
            end
            ST_DIV_SLOT: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DS_SLOT;
            end
            ST_ADV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DS_ADV;
                o_cmd.scan_clr  = 1'b1;
            end
            ST_START_FIN: begin
                o_cmd.arm_write    = i_sts.out_free;
                o_cmd.start_commit = i_sts.out_free;
            end
            ST_STOP:     o_cmd.stop_commit = i_sts.out_free;
            ST_SCAN:     o_cmd.scan_visit = !i_sts.scan_end && !i_sts.expire;
            ST_REARM:    o_cmd.arm_write = 1'b1;
            ST_EXPIRE:   o_cmd.expire_commit = i_sts.out_free;
            ST_TICK_FIN: o_cmd.tick_done = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

// File: hdl/htw_dp.sv
// Timer table, wheel state, counters and result register.
`include "hashed_timing_wheel_unit_macros.svh"
module htw_dp #(
    parameter int MAX_TIMERS  = 32,
    parameter int WHEEL_SLOTS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  htw_pkg::t_dp_cmd   i_cmd,
    output htw_pkg::t_dp_sts   o_sts,
    input  htw_pkg::t_in_item  i_in_item,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output htw_pkg::t_out_item o_out_item
);
    import htw_pkg::*;

    localparam int IW  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW  = $clog2(MAX_TIMERS + 1);
    localparam int SW  = $clog2(WHEEL_SLOTS);
    localparam int SCW = SW + 1;

    logic [15:0]   r_gran;
    logic [8:0]    r_slots;
    t_in_item      r_in;
    logic          r_flag   [MAX_TIMERS];
    logic [SW-1:0] r_aslot  [MAX_TIMERS];
    logic [31:0]   r_rounds [MAX_TIMERS];
    logic [31:0]   r_reload [MAX_TIMERS];
    logic [SW-1:0] r_cur;
    logic [CW-1:0] r_idx;
    logic [5:0]    r_count;
    logic [5:0]    r_peak;
    logic [31:0]   r_exp_total;
    t_div_sel      r_dsel;
    logic [31:0]   r_ticks;
    logic [31:0]   r_arm_rounds;
    logic [SCW-1:0] r_arm_rem;
    logic [SW-1:0] r_arm_slot;
    logic          r_out_valid;
    t_out_item     r_out;

    logic          is_tick;
    logic [IW-1:0] idx;
    logic [IW-1:0] tgt;
    logic [8:0]    s9;
    logic [SCW-1:0] eff_s;
    logic [15:0]   gran_eff;
    logic [31:0]   div_num;
    logic [15:0]   div_den;
    logic          div_done;
    logic [31:0]   div_quo;
    logic [15:0]   div_rem;
    logic          was;
    logic          hit;
    logic          periodic;
    logic          out_free;
    logic          emit;
    logic [31:0]   arm_rounds_w;
    logic [5:0]    n_count;
    logic [5:0]    n_peak;
    logic [31:0]   n_exp_total;
    t_out_item     n_out;

    assign is_tick  = r_in.action == ACT_TICK;
    assign idx      = r_idx[IW-1:0];
    assign tgt      = is_tick ? idx : IW'(r_in.timer_id);
    assign s9       = (r_slots < 9'd2) ? 9'd2 :
                      (r_slots > 9'(WHEEL_SLOTS)) ? 9'(WHEEL_SLOTS) : r_slots;
    assign eff_s    = s9[SCW-1:0];
    assign gran_eff = (r_gran == 16'd0) ? 16'd1 : r_gran;
    assign was      = r_flag[tgt];
    assign hit      = r_flag[idx] && (r_aslot[idx] == r_cur);
    assign periodic = r_reload[idx] != 32'd0;
    assign out_free = !r_out_valid || i_out_ready;
    assign emit     = i_cmd.start_commit || i_cmd.stop_commit ||
                      i_cmd.expire_commit || i_cmd.tick_done;

    always_comb begin
        div_num = 32'(r_cur) + 32'd1;
        div_den = 16'(eff_s);
        case (i_cmd.div_sel)
            DS_TICKS: begin
                div_num = is_tick ? r_reload[idx] : r_in.delay;
                div_den = gran_eff;
            end
            DS_ROUNDS: div_num = r_ticks;
            DS_SLOT:   div_num = 32'(r_cur) + 32'(r_arm_rem);
            default:   div_num = 32'(r_cur) + 32'd1;
        endcase
    end

    htw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // re-armed timer landing on the current slot loses one round now
    assign arm_rounds_w = (is_tick && r_arm_slot == r_cur && r_arm_rounds != 32'd0) ?
                          r_arm_rounds - 32'd1 : r_arm_rounds;

    always_comb begin
        n_count     = r_count;
        n_exp_total = r_exp_total;
        n_out       = '0;
        if (i_cmd.start_commit) begin
            n_count           = r_count - 6'(was) + 6'd1;
            n_out.kind        = KIND_START;
            n_out.handle      = r_in.timer_id;
            n_out.was_running = was;
            n_out.last        = 1'b1;
        end else if (i_cmd.stop_commit) begin
            n_count           = r_count - 6'(was);
            n_out.kind        = KIND_STOP;
            n_out.handle      = r_in.timer_id;
            n_out.was_running = was;
            n_out.last        = 1'b1;
        end else if (i_cmd.expire_commit) begin
            n_count      = periodic ? r_count : r_count - 6'd1;
            n_exp_total  = r_exp_total + 32'd1;
            n_out.kind   = KIND_EXPIRED;
            n_out.handle = 5'(idx);
        end else begin
            n_out.kind = KIND_TICK;
            n_out.last = 1'b1;
        end
        n_peak              = (n_count > r_peak) ? n_count : r_peak;
        n_out.active_count  = n_count;
        n_out.hiwater_mark  = n_peak;
        n_out.expired_total = n_exp_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gran      <= 16'd1;
            r_slots     <= 9'd256;
            r_cur       <= '0;
            r_idx       <= '0;
            r_count     <= '0;
            r_peak      <= '0;
            r_exp_total <= '0;
            r_out_valid <= 1'b0;
            r_dsel      <= DS_TICKS;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_GRAN) r_gran <= i_cfg_data;
                else r_slots <= i_cfg_data[8:0];
            end
            if (i_cmd.div_start) r_dsel <= i_cmd.div_sel;
            if (div_done && r_dsel == DS_ADV) r_cur <= div_rem[SW-1:0];
            if (i_cmd.scan_clr) r_idx <= '0;
            else if (i_cmd.scan_visit || i_cmd.expire_commit) r_idx <= r_idx + 1'b1;
            if (emit) begin
                r_count     <= n_count;
                r_peak      <= n_peak;
                r_exp_total <= n_exp_total;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_TIMERS; k++) r_flag[k] <= 1'b0;
        end else begin
            if (i_cmd.start_commit) r_flag[tgt] <= 1'b1;
            else if (i_cmd.stop_commit) r_flag[tgt] <= 1'b0;
            else if (i_cmd.expire_commit && !periodic) r_flag[idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) r_in <= i_in_item;
        if (emit) r_out <= n_out;
        if (div_done) begin
            case (r_dsel)
                DS_TICKS:  r_ticks <= (div_quo == 32'd0) ? 32'd1 : div_quo;
                DS_ROUNDS: begin
                    r_arm_rounds <= div_quo;
                    r_arm_rem    <= div_rem[SCW-1:0];
                end
                DS_SLOT:   r_arm_slot <= div_rem[SW-1:0];
                default: ;
            endcase
        end
        if (i_cmd.start_commit) r_reload[tgt] <= r_in.reload_interval;
        if (i_cmd.arm_write) begin
            r_aslot[tgt]  <= r_arm_slot;
            r_rounds[tgt] <= arm_rounds_w;
        end else if (i_cmd.scan_visit && hit) begin
            r_rounds[idx] <= r_rounds[idx] - 32'd1;
        end
    end

    assign o_sts.action   = r_in.action;
    assign o_sts.id_ok    = 32'(r_in.timer_id) < MAX_TIMERS;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = out_free;
    assign o_sts.scan_end = r_idx == CW'(MAX_TIMERS);
    assign o_sts.expire   = hit && (r_rounds[idx] == 32'd0);
    assign o_sts.periodic = periodic;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `HTW_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, 32'(r_count) <= MAX_TIMERS)
    `HTW_ASSERT_NOW(a_peak_cover, i_clk, i_rst_n, 1'b1, r_peak >= r_count)
    `HTW_ASSERT_NEXT(a_exp_only_on_expiry, i_clk, i_rst_n, !i_cmd.expire_commit,
        $stable(r_exp_total))
    `HTW_ASSERT_NOW(a_emit_room, i_clk, i_rst_n, emit, out_free)

endmodule

// File: hdl/hashed_timing_wheel_unit.sv
// Top level of the hashed timing wheel: sequencer plus datapath.
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item at a time. Stop needs no divider pass. Start: 3 divider passes.
// Tick: one divider pass (slot advance), then one timer entry per cycle while
// no entry expires, plus the same passes as a start per periodic re-arm; one
// shared serial divider runs all of these passes.
// Reset (i_rst_n low, synchronous) clears all timers, counters and the slot.
// A stalled result holds the sequencer only when the next result is due.
module hashed_timing_wheel_unit #(
    parameter int MAX_TIMERS  = 32,
    parameter int WHEEL_SLOTS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  htw_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output htw_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import htw_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // config writes are always taken; user must write only while idle, unenforced
    assign o_cfg_ready = 1'b1;

    htw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    htw_dp #(
        .MAX_TIMERS  (MAX_TIMERS),
        .WHEEL_SLOTS (WHEEL_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
